@@ hw/rtl/rfd_pkg.sv @@
`default_nettype none

package rfd_pkg;

  // Frame layout
  localparam int FRAME_BYTES_USED = 16;
  localparam int IDX_W            = $clog2(FRAME_BYTES_USED);
  localparam int COUNT_W          = $clog2(FRAME_BYTES_USED + 1);

  localparam int STICK_W = 11;
  localparam int CFG_W   = 13;

  localparam logic [STICK_W-1:0] STICK_LOW    = 11'd364;
  localparam logic [STICK_W-1:0] STICK_HIGH   = 11'd1684;
  localparam logic [STICK_W-1:0] STICK_CENTRE = 11'd1024;

  // Division by 660 of a magnitude below 2**24: floor(n * RECIP >> SHIFT) is exact
  localparam int MAG_W       = 24;
  localparam int RECIP_W     = 25;
  localparam int RECIP_SHIFT = 34;
  localparam int QUOT_W      = MAG_W + RECIP_W - RECIP_SHIFT;
  localparam logic [RECIP_W-1:0] DIV660_RECIP = 25'd26030105;

  // Yaw gain is 8192, a shift by this many bits
  localparam int YAW_SHIFT = 13;

  typedef enum logic [1:0] {
    CFG_PITCH_ZERO = 2'd0,
    CFG_PITCH_MIN  = 2'd1,
    CFG_PITCH_MAX  = 2'd2
  } cfg_idx_t;

  localparam logic [CFG_W-1:0] PITCH_ZERO_RESET = 13'd4096;
  localparam logic [CFG_W-1:0] PITCH_MIN_RESET  = 13'd3000;
  localparam logic [CFG_W-1:0] PITCH_MAX_RESET  = 13'd5200;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       frame_end;
  } rfd_in_t;

  typedef struct packed {
    logic               frame_ok;
    logic [43:0]        sticks;
    logic [3:0]         switches;
    logic signed [15:0] mouse_x;
    logic signed [15:0] mouse_y;
    logic signed [15:0] mouse_z;
    logic [1:0]         mouse_buttons;
    logic [15:0]        key_mask;
    logic signed [15:0] yaw_command;
    logic signed [15:0] pitch_command;
    logic               relative_mode;
  } rfd_out_t;

  typedef struct packed {
    logic [43:0]        sticks;
    logic [3:0]         switches;
    logic signed [15:0] mouse_x;
    logic signed [15:0] mouse_y;
    logic signed [15:0] mouse_z;
    logic [1:0]         buttons;
    logic [15:0]        keys;
  } rfd_held_t;

  typedef struct packed {
    logic      frame_ok;
    rfd_held_t held;
  } rfd_snap_t;

  localparam rfd_held_t HELD_RESET = '{
    sticks:   {4{STICK_CENTRE}},
    switches: 4'hF,
    mouse_x:  16'sd0,
    mouse_y:  16'sd0,
    mouse_z:  16'sd0,
    buttons:  2'b00,
    keys:     16'h0000
  };

endpackage

`default_nettype wire

@@ hw/rtl/rfd_frame_rx.sv @@
`default_nettype none

module rfd_frame_rx
  import rfd_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      load_byte,
  input  wire rfd_in_t   item,
  output rfd_snap_t      snap
);

  logic [7:0]         frame_store [FRAME_BYTES_USED];
  logic [7:0]         view [FRAME_BYTES_USED];
  logic [COUNT_W-1:0] byte_count;
  logic [COUNT_W-1:0] byte_count_next;
  logic               store_open;
  logic               full_frame;
  logic [1:0]         sw_left;
  logic [1:0]         sw_right;
  logic [STICK_W-1:0] ch [4];
  logic               sticks_ok;
  logic               frame_valid;
  logic               accept_frame;
  rfd_held_t          decoded;

  assign store_open = byte_count < COUNT_W'(FRAME_BYTES_USED);
  // the frame-end byte fills the last entry when the count sits one short
  assign full_frame = byte_count >= COUNT_W'(FRAME_BYTES_USED - 1);

  always_comb begin
    byte_count_next = byte_count;
    if (load_byte) begin
      if (item.frame_end) begin
        byte_count_next = '0;
      end else if (store_open) begin
        byte_count_next = byte_count + COUNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count <= '0;
    end else begin
      byte_count <= byte_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load_byte && store_open) begin
      frame_store[byte_count[IDX_W-1:0]] <= item.rx_byte;
    end
  end

  // Store contents with the byte now arriving merged in
  always_comb begin
    for (int i = 0; i < FRAME_BYTES_USED; i++) begin
      view[i] = (byte_count == COUNT_W'(i)) ? item.rx_byte : frame_store[i];
    end
  end

  assign sw_left  = view[5][7:6];
  assign sw_right = view[5][5:4];
  assign ch[0] = {view[1][2:0], view[0]};
  assign ch[1] = {view[2][5:0], view[1][7:3]};
  assign ch[2] = {view[4][0], view[3], view[2][7:6]};
  assign ch[3] = {view[5][3:0], view[4][7:1]};

  always_comb begin
    sticks_ok = 1'b1;
    for (int i = 0; i < 4; i++) begin
      if (!(ch[i] > STICK_LOW && ch[i] < STICK_HIGH)) begin
        sticks_ok = 1'b0;
      end
    end
  end

  assign frame_valid = (sw_left != 2'b00) && (sw_right != 2'b00) &&
                       (view[12] <= 8'd1) && (view[13] <= 8'd1) && sticks_ok;
  assign accept_frame = full_frame && frame_valid;

  always_comb begin
    decoded.sticks   = {ch[3], ch[2], ch[1], ch[0]};
    decoded.switches = {sw_left, sw_right};
    decoded.mouse_x  = $signed({view[7], view[6]});
    decoded.mouse_y  = $signed({view[9], view[8]});
    decoded.mouse_z  = $signed({view[11], view[10]});
    decoded.buttons  = {view[13][0], view[12][0]};
    decoded.keys     = {view[15], view[14]};
  end

  // Held values change only on a good frame; keep them otherwise
  always_ff @(posedge clk) begin
    if (rst) begin
      snap <= '{frame_ok: 1'b0, held: HELD_RESET};
    end else if (load_byte && item.frame_end) begin
      snap.frame_ok <= accept_frame;
      if (accept_frame) begin
        snap.held <= decoded;
      end
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/rfd_cmd_pipe.sv @@
`default_nettype none

module rfd_cmd_pipe
  import rfd_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             load,
  input  wire rfd_snap_t        snap,
  input  wire logic [CFG_W-1:0] pitch_zero,
  input  wire logic [CFG_W-1:0] pitch_min,
  input  wire logic [CFG_W-1:0] pitch_max,
  output logic                  s1_free,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output rfd_out_t              out_item
);

  logic s1_valid, s2_valid, s3_valid;
  logic s2_free, s3_free, out_free;

  // Stage 2: operand magnitudes, pitch gain product, mouse scaling
  rfd_snap_t          s2_snap;
  logic [MAG_W-1:0]   s2_yaw_mag;
  logic               s2_yaw_neg;
  logic [MAG_W-1:0]   s2_pitch_mag;
  logic               s2_pitch_neg;
  logic signed [15:0] s2_rel_yaw;
  logic signed [15:0] s2_rel_pitch;

  // Stage 3: quotients by 660
  rfd_snap_t          s3_snap;
  logic [QUOT_W-1:0]  s3_yaw_q;
  logic               s3_yaw_neg;
  logic [QUOT_W-1:0]  s3_pitch_q;
  logic               s3_pitch_neg;
  logic signed [15:0] s3_rel_yaw;
  logic signed [15:0] s3_rel_pitch;

  logic [STICK_W-1:0]         ch0, ch1;
  logic signed [STICK_W:0]    yaw_diff, pitch_diff;
  logic [STICK_W:0]           yaw_abs, pitch_abs;
  logic signed [CFG_W:0]      gain;
  logic [CFG_W:0]             gain_abs;
  logic signed [15:0]         mx_adj, my_adj;
  logic [MAG_W+RECIP_W-1:0]   yaw_prod, pitch_prod;
  logic signed [15:0]         yaw_abs_cmd, pitch_q_s;
  logic signed [16:0]         pitch_sum;
  logic signed [15:0]         pitch_wrap, pitch_abs_cmd;
  logic signed [15:0]         pitch_limit;
  logic                       rel;

  assign out_free = !out_valid || out_ready;
  assign s3_free  = !s3_valid || out_free;
  assign s2_free  = !s2_valid || s3_free;
  assign s1_free  = !s1_valid || s2_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      s3_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s1_free) begin
        s1_valid <= load;
      end
      if (s2_free) begin
        s2_valid <= s1_valid;
      end
      if (s3_free) begin
        s3_valid <= s2_valid;
      end
      if (out_free) begin
        out_valid <= s3_valid;
      end
    end
  end

  // Stage 1 payload is the held snapshot itself
  assign ch0        = snap.held.sticks[STICK_W-1:0];
  assign ch1        = snap.held.sticks[2*STICK_W-1:STICK_W];
  assign yaw_diff   = $signed({1'b0, ch0}) - $signed({1'b0, STICK_LOW});
  assign pitch_diff = $signed({1'b0, ch1}) - $signed({1'b0, STICK_CENTRE});
  assign yaw_abs    = yaw_diff[STICK_W] ? (STICK_W+1)'(-yaw_diff) : (STICK_W+1)'(yaw_diff);
  assign pitch_abs  = pitch_diff[STICK_W] ? (STICK_W+1)'(-pitch_diff)
                                          : (STICK_W+1)'(pitch_diff);
  assign gain       = $signed({1'b0, pitch_zero}) - $signed({1'b0, pitch_min});
  assign gain_abs   = gain[CFG_W] ? (CFG_W+1)'(-gain) : (CFG_W+1)'(gain);

  // Truncating divide by four: bias negatives by three before the shift
  assign mx_adj = snap.held.mouse_x + (snap.held.mouse_x[15] ? 16'sd3 : 16'sd0);
  assign my_adj = snap.held.mouse_y + (snap.held.mouse_y[15] ? 16'sd3 : 16'sd0);

  always_ff @(posedge clk) begin
    if (s2_free) begin
      s2_snap      <= snap;
      s2_yaw_mag   <= MAG_W'({yaw_abs[STICK_W-1:0], YAW_SHIFT'(0)});
      s2_yaw_neg   <= yaw_diff[STICK_W];
      s2_pitch_mag <= MAG_W'(pitch_abs[STICK_W-1:0] * gain_abs[CFG_W-1:0]);
      s2_pitch_neg <= pitch_diff[STICK_W] ^ gain[CFG_W];
      s2_rel_yaw   <= mx_adj >>> 2;
      s2_rel_pitch <= my_adj >>> 2;
    end
  end

  assign yaw_prod   = s2_yaw_mag * DIV660_RECIP;
  assign pitch_prod = s2_pitch_mag * DIV660_RECIP;

  always_ff @(posedge clk) begin
    if (s3_free) begin
      s3_snap      <= s2_snap;
      s3_yaw_q     <= yaw_prod[MAG_W+RECIP_W-1:RECIP_SHIFT];
      s3_yaw_neg   <= s2_yaw_neg;
      s3_pitch_q   <= pitch_prod[MAG_W+RECIP_W-1:RECIP_SHIFT];
      s3_pitch_neg <= s2_pitch_neg;
      s3_rel_yaw   <= s2_rel_yaw;
      s3_rel_pitch <= s2_rel_pitch;
    end
  end

  assign rel         = s3_snap.held.switches[1:0] == 2'b01;
  assign yaw_abs_cmd = s3_yaw_neg ? -$signed({1'b0, s3_yaw_q}) : $signed({1'b0, s3_yaw_q});
  assign pitch_q_s   = s3_pitch_neg ? -$signed({1'b0, s3_pitch_q})
                                    : $signed({1'b0, s3_pitch_q});
  assign pitch_sum   = 17'(pitch_q_s) + $signed({4'b0, pitch_zero});
  assign pitch_wrap  = pitch_sum[15:0];
  assign pitch_limit = $signed({3'b0, pitch_max});
  assign pitch_abs_cmd = (pitch_wrap > pitch_limit) ? pitch_limit : pitch_wrap;

  always_ff @(posedge clk) begin
    if (out_free) begin
      out_item.frame_ok      <= s3_snap.frame_ok;
      out_item.sticks        <= s3_snap.held.sticks;
      out_item.switches      <= s3_snap.held.switches;
      out_item.mouse_x       <= s3_snap.held.mouse_x;
      out_item.mouse_y       <= s3_snap.held.mouse_y;
      out_item.mouse_z       <= s3_snap.held.mouse_z;
      out_item.mouse_buttons <= s3_snap.held.buttons;
      out_item.key_mask      <= s3_snap.held.keys;
      out_item.yaw_command   <= rel ? s3_rel_yaw : yaw_abs_cmd;
      out_item.pitch_command <= rel ? s3_rel_pitch : pitch_abs_cmd;
      out_item.relative_mode <= rel;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/remote_frame_decode_gimbal_command.sv @@
// Channel  Signals                                   Direction
// -------  ----------------------------------------  ---------
// in       in_valid, in_ready, in_item (rfd_in_t)    sink
// out      out_valid, out_ready, out_item (rfd_out_t) source
// cfg      cfg_valid, cfg_ready, cfg_index, cfg_data sink
//
// One byte item is taken every cycle while in_ready is high. A frame-end item
// yields one result, offered at the output through a four-register chain
// (held snapshot, gain product, reciprocal multiply by 1/660, output).
// Each stage advances on its own, so in_ready drops only when all four are
// full and out_ready is low. Synchronous reset zeroes the byte count and the
// valids and restores held values and pitch registers; cfg_ready is high.
`default_nettype none

module remote_frame_decode_gimbal_command
  import rfd_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire rfd_in_t          in_item,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output rfd_out_t              out_item,
  input  wire logic             cfg_valid,
  output logic                  cfg_ready,
  input  wire logic [1:0]       cfg_index,
  input  wire logic [CFG_W-1:0] cfg_data
);

  logic             in_accept;
  logic [CFG_W-1:0] pitch_zero;
  logic [CFG_W-1:0] pitch_min;
  logic [CFG_W-1:0] pitch_max;
  rfd_snap_t        snap;

  assign cfg_ready = 1'b1;
  assign in_accept = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pitch_zero <= PITCH_ZERO_RESET;
      pitch_min  <= PITCH_MIN_RESET;
      pitch_max  <= PITCH_MAX_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_idx_t'(cfg_index))
        CFG_PITCH_ZERO: pitch_zero <= cfg_data;
        CFG_PITCH_MIN:  pitch_min  <= cfg_data;
        CFG_PITCH_MAX:  pitch_max  <= cfg_data;
        default: ;
      endcase
    end
  end

  rfd_frame_rx u_frame_rx (
    .clk       (clk),
    .rst       (rst),
    .load_byte (in_accept),
    .item      (in_item),
    .snap      (snap)
  );

  rfd_cmd_pipe u_cmd_pipe (
    .clk        (clk),
    .rst        (rst),
    .load       (in_accept && in_item.frame_end),
    .snap       (snap),
    .pitch_zero (pitch_zero),
    .pitch_min  (pitch_min),
    .pitch_max  (pitch_max),
    .s1_free    (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_item   (out_item)
  );

`ifndef SYNTHESIS
  // Input stalls only when the whole chain is full behind a stalled result
  assert property (@(posedge clk) disable iff (rst) !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without a blocked result");

  // Held switches are never zero, so neither is any reported switch
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_item.switches[3:2] != 2'b00 && out_item.switches[1:0] != 2'b00)
    else $error("result carries a zero switch");

  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_item.relative_mode == (out_item.switches[1:0] == 2'b01))
    else $error("mode does not follow the right switch");
`endif

endmodule

`default_nettype wire
